// ===== hw/rtl/lpsd_pkg.sv =====
// Package for the length-prefixed stream deframer.
// Holds the phase and result-kind codes, header sizes and the result record.
// No dependencies.
package lpsd_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned PREFIX_BYTES = 4;

  localparam logic [3:0] HEADER_SIZE = 4'(HEADER_BYTES);
  localparam logic [3:0] PREFIX_SIZE = 4'(PREFIX_BYTES);

  localparam logic [24:0] MAX_PACKET_RESET = 25'd65536;

  typedef enum logic {
    PHASE_HEADER = 1'b0,
    PHASE_BODY   = 1'b1
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_BAD   = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_FRAMING_MODE = 1'b0,
    CFG_MAX_PACKET   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [31:0] bad_length;
    logic [31:0] session_id;
    logic [31:0] message_id;
    logic [7:0]  data_byte;
    logic        last;
    kind_t       kind;
  } result_t;

endpackage

// ===== hw/rtl/lpsd_core.sv =====
// Framing state of the deframer: header collection, length check, body count.
// Holds the configuration registers. Depends on lpsd_pkg.
module lpsd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  lpsd_pkg::cfg_index_t  cfg_sel,
  input  logic [24:0]           cfg_value,
  input  logic                  item_valid,
  input  logic [7:0]            item_byte,
  output logic                  res_valid,
  output lpsd_pkg::result_t     res
);

  logic        framing_mode;
  logic [24:0] max_packet_bytes;

  lpsd_pkg::phase_t phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [31:0] frame_length, frame_length_next;
  logic [31:0] held_message_id, held_message_id_next;
  logic [31:0] held_session_id, held_session_id_next;
  logic [31:0] body_remaining, body_remaining_next;
  logic        closed, closed_next;

  logic [3:0]  count_inc;
  logic [3:0]  hsize;
  logic [31:0] hsize_w;
  logic [31:0] len_new;
  logic        header_done;
  logic        len_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      framing_mode     <= 1'b0;
      max_packet_bytes <= lpsd_pkg::MAX_PACKET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        lpsd_pkg::CFG_FRAMING_MODE: framing_mode     <= cfg_value[0];
        lpsd_pkg::CFG_MAX_PACKET:   max_packet_bytes <= cfg_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lpsd_pkg::PHASE_HEADER;
      header_count    <= '0;
      frame_length    <= '0;
      held_message_id <= '0;
      held_session_id <= '0;
      body_remaining  <= '0;
      closed          <= 1'b0;
    end else begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      frame_length    <= frame_length_next;
      held_message_id <= held_message_id_next;
      held_session_id <= held_session_id_next;
      body_remaining  <= body_remaining_next;
      closed          <= closed_next;
    end
  end

  assign count_inc = header_count + 4'd1;
  assign hsize     = framing_mode ? lpsd_pkg::PREFIX_SIZE : lpsd_pkg::HEADER_SIZE;
  assign hsize_w   = {28'd0, hsize};
  assign len_new   = (header_count < 4'd4) ? {frame_length[23:0], item_byte} : frame_length;
  assign header_done = (count_inc >= hsize);
  assign len_bad   = (len_new < hsize_w) || (len_new > {7'd0, max_packet_bytes});

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    frame_length_next    = frame_length;
    held_message_id_next = held_message_id;
    held_session_id_next = held_session_id;
    body_remaining_next  = body_remaining;
    closed_next          = closed;
    res_valid            = 1'b0;
    res                  = '0;
    res.kind             = lpsd_pkg::KIND_BODY;

    if (item_valid && !closed) begin
      unique case (phase)
        lpsd_pkg::PHASE_BODY: begin
          res_valid          = 1'b1;
          res.kind           = lpsd_pkg::KIND_BODY;
          res.data_byte      = item_byte;
          res.message_id     = held_message_id;
          res.session_id     = held_session_id;
          res.last           = (body_remaining <= 32'd1);
          if (body_remaining > 32'd1) begin
            body_remaining_next = body_remaining - 32'd1;
          end else begin
            body_remaining_next = '0;
            phase_next          = lpsd_pkg::PHASE_HEADER;
          end
        end
        lpsd_pkg::PHASE_HEADER: begin
          frame_length_next = len_new;
          if (header_count >= 4'd4 && header_count < 4'd8) begin
            held_message_id_next = {held_message_id[23:0], item_byte};
          end else if (header_count >= 4'd8) begin
            held_session_id_next = {held_session_id[23:0], item_byte};
          end
          header_count_next = count_inc;

          if (header_done) begin
            header_count_next = '0;
            // prefix mode reports zero ids
            if (framing_mode) begin
              held_message_id_next = '0;
              held_session_id_next = '0;
            end
            if (len_bad) begin
              res_valid      = 1'b1;
              res.kind       = lpsd_pkg::KIND_BAD;
              res.bad_length = len_new;
              closed_next    = 1'b1;
            end else begin
              body_remaining_next = len_new - hsize_w;
              if (len_new == hsize_w) begin
                res_valid      = 1'b1;
                res.kind       = lpsd_pkg::KIND_EMPTY;
                res.message_id = held_message_id_next;
                res.session_id = held_session_id_next;
                res.last       = 1'b1;
              end else begin
                phase_next = lpsd_pkg::PHASE_BODY;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lpsd_skid.sv =====
// Two-entry output buffer: result register plus skid register.
// Input ready comes from a register. Depends on lpsd_pkg.
module lpsd_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lpsd_pkg::result_t  push_data,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output lpsd_pkg::result_t  out_data
);

  lpsd_pkg::result_t skid_data;
  logic              skid_valid;
  logic              pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // drain skid into the output register
        if (pop) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

// ===== hw/rtl/length_prefixed_stream_deframer_unit.sv =====
// Top level of the length-prefixed stream deframer.
// Depends on lpsd_pkg, lpsd_core and lpsd_skid.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata: rx_byte
//  m_*      | out       | m_tvalid/m_tready  | tdata, tuser: kind, tlast: last
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte is accepted every cycle while s_tready is high; each byte's result (if any)
// goes to the output register, or to the skid register while the output is stalled.
// Header decode, length check and body count sit between the framing state registers
// and the two-entry output buffer. rst (synchronous) returns to header collection,
// opens the block and restores framing_mode 0 and max_packet_bytes 65536. With
// m_tready low, one more transaction fits in the skid register before s_tready drops.
module length_prefixed_stream_deframer_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] rx_byte
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // [7:0] data_byte, [39:8] message_id,
                                   // [71:40] session_id, [103:72] bad_length
  output logic [1:0]    m_tuser,   // [1:0] kind
  output logic          m_tlast,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [24:0]   cfg_data
);

  lpsd_pkg::result_t res;
  lpsd_pkg::result_t out_res;
  logic              res_valid;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  lpsd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_sel    (lpsd_pkg::cfg_index_t'(cfg_index)),
    .cfg_value  (cfg_data),
    .item_valid (accept),
    .item_byte  (s_tdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  lpsd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.bad_length, out_res.session_id,
                    out_res.message_id, out_res.data_byte};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule
